// ----- rtl/rrld_pkg.sv -----
`default_nettype none

package rrld_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int LW_BITS = 13;
  localparam logic [LW_BITS-1:0] LINE_WIDTH_RESET = 13'd4096;

  localparam logic [7:0] HDR_EOL_HI = 8'h80;
  localparam logic [7:0] HDR_EOL_LO = 8'h00;
  localparam int HDR_RUN_BIT = 7;
  localparam int HDR_ZERO_BIT = 6;
  localparam logic [7:0] RUN_MASK = 8'h3F;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_RUN_B  = 7'b0000010,
    PH_RUN_G  = 7'b0000100,
    PH_RUN_R  = 7'b0001000,
    PH_LIT_B  = 7'b0010000,
    PH_LIT_G  = 7'b0100000,
    PH_LIT_R  = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_EOL  = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_LIT  = 2'd2,
    CMD_HOLD = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [5:0] count;
    logic       opaque;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [LW_BITS-1:0] repeat_count;
    logic               end_of_line;
    logic               overrun;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/rgb_rle_line_decoder.sv -----
`default_nettype none

// Run-length line decoder for RGB images.
// Input channel: one coded byte per word on in_code_byte, written with
// in_push while in_full is low. Result channel: one pixel run per word on
// out_red/green/blue/alpha/repeat_count with out_end_of_line and
// out_overrun; read with out_pop while out_empty is low, oldest first.
// Header, blue and green bytes yield no word; a zero run and an end-of-line
// header yield one; a red byte does too unless a literal overruns the line.
// Throughput: one coded byte per cycle while in_full is low, set by the
// parser and by the run executor that drains the command queue.
// Path: the parser writes a byte's command into the command queue as the
// byte is taken; the command waits in that queue until the executor pops
// it and writes its word into the result queue, which drives the ports.
// cfg_we with cfg_line_width sets the line width; values above MAX_WIDTH
// act as MAX_WIDTH. Write it only while no words are in flight.
// Reset: parser back to expecting a header, pixel count and overrun flag
// cleared, both queues empty, line width 4096 (MAX_WIDTH if smaller).
// When the receiver stalls, the result queue fills, then the command queue,
// then in_full rises; nothing is dropped.
module rgb_rle_line_decoder
  import rrld_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [LW_BITS-1:0] cfg_line_width,
  input  wire logic               in_push,
  input  wire logic [7:0]         in_code_byte,
  output logic                    in_full,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic [7:0]              out_alpha,
  output logic [LW_BITS-1:0]      out_repeat_count,
  output logic                    out_end_of_line,
  output logic                    out_overrun
);

  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic res_push, res_full;
  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;

  assign in_full = cmd_full;

  rrld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_push && !cmd_full),
    .code_byte  (in_code_byte),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  rrld_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  rrld_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_line_width (cfg_line_width),
    .cmd            (cmd_out),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res_in)
  );

  rrld_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_red          = res_out.red;
  assign out_green        = res_out.green;
  assign out_blue         = res_out.blue;
  assign out_alpha        = res_out.alpha;
  assign out_repeat_count = res_out.repeat_count;
  assign out_end_of_line  = res_out.end_of_line;
  assign out_overrun      = res_out.overrun;

endmodule

`default_nettype wire

// ----- rtl/rrld_fifo.sv -----
`default_nettype none

module rrld_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo count above depth");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("fifo empty after push");

endmodule

`default_nettype wire

// ----- rtl/rrld_front.sv -----
`default_nettype none

module rrld_front
  import rrld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] code_byte,
  output logic            cmd_push,
  output cmd_t            cmd
);

  phase_t     phase_r, phase_nxt;
  logic [6:0] literal_left_r, literal_left_nxt;
  logic [7:0] held_blue_r, held_blue_nxt;
  logic [7:0] held_green_r, held_green_nxt;
  logic [6:0] lit_dec;

  assign lit_dec = literal_left_r - 1'b1;

  always_comb begin
    phase_nxt        = phase_r;
    literal_left_nxt = literal_left_r;
    held_blue_nxt    = held_blue_r;
    held_green_nxt   = held_green_r;
    cmd_push         = 1'b0;
    cmd.kind         = CMD_EOL;
    cmd.count        = '0;
    cmd.opaque       = 1'b0;
    cmd.red          = '0;
    cmd.green        = '0;
    cmd.blue         = '0;
    if (byte_valid) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (code_byte == HDR_EOL_HI || code_byte == HDR_EOL_LO) begin
            cmd_push = 1'b1;
          end else if (code_byte[HDR_RUN_BIT]) begin
            if (code_byte[HDR_ZERO_BIT]) begin
              cmd_push  = 1'b1;
              cmd.kind  = CMD_RUN;
              cmd.count = 6'(code_byte & RUN_MASK);
            end else begin
              cmd_push  = 1'b1;
              cmd.kind  = CMD_HOLD;
              cmd.count = 6'(code_byte & RUN_MASK);
              phase_nxt = PH_RUN_B;
            end
          end else begin
            literal_left_nxt = code_byte[6:0];
            phase_nxt        = PH_LIT_B;
          end
        end
        PH_RUN_B: begin
          held_blue_nxt = code_byte;
          phase_nxt     = PH_RUN_G;
        end
        PH_RUN_G: begin
          held_green_nxt = code_byte;
          phase_nxt      = PH_RUN_R;
        end
        PH_RUN_R: begin
          cmd_push   = 1'b1;
          cmd.kind   = CMD_RUN;
          cmd.opaque = 1'b1;
          cmd.red    = code_byte;
          cmd.green  = held_green_r;
          cmd.blue   = held_blue_r;
          phase_nxt  = PH_HEADER;
        end
        PH_LIT_B: begin
          held_blue_nxt = code_byte;
          phase_nxt     = PH_LIT_G;
        end
        PH_LIT_G: begin
          held_green_nxt = code_byte;
          phase_nxt      = PH_LIT_R;
        end
        PH_LIT_R: begin
          cmd_push         = 1'b1;
          cmd.kind         = CMD_LIT;
          cmd.count        = 6'd1;
          cmd.opaque       = 1'b1;
          cmd.red          = code_byte;
          cmd.green        = held_green_r;
          cmd.blue         = held_blue_r;
          literal_left_nxt = lit_dec;
          phase_nxt        = (lit_dec == '0) ? PH_HEADER : PH_LIT_B;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      literal_left_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      literal_left_r <= literal_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_blue_r  <= held_blue_nxt;
    held_green_r <= held_green_nxt;
  end

  a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (phase_r == PH_HEADER || phase_r == PH_RUN_R || phase_r == PH_LIT_R))
    else $error("command from a color byte that does not close a pixel");

  a_lit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LIT_B || phase_r == PH_LIT_G || phase_r == PH_LIT_R)
      |-> (literal_left_r != '0))
    else $error("literal phase with no literals left");

endmodule

`default_nettype wire

// ----- rtl/rrld_back.sv -----
`default_nettype none

module rrld_back
  import rrld_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [LW_BITS-1:0] cfg_line_width,
  input  wire cmd_t               cmd,
  input  wire logic               cmd_empty,
  output logic                    cmd_pop,
  input  wire logic               res_full,
  output logic                    res_push,
  output res_t                    res
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int LW = (CW > LW_BITS) ? CW : LW_BITS;

  logic [CW-1:0] eff_width_r, eff_width_nxt;
  logic [CW-1:0] done_r, done_nxt;
  logic          ovr_r, ovr_nxt;
  logic [5:0]    pending_r, pending_nxt;
  logic [5:0]    run_cnt;
  logic [LW-1:0] left, clamp, cnt_ext;

  always_comb begin
    eff_width_nxt = eff_width_r;
    if (cfg_we) begin
      if (LW'(cfg_line_width) > LW'(MAX_WIDTH)) begin
        eff_width_nxt = CW'(MAX_WIDTH);
      end else begin
        eff_width_nxt = CW'(cfg_line_width);
      end
    end
  end

  assign left    = (done_r < eff_width_r) ? LW'(eff_width_r - done_r) : '0;
  assign run_cnt = (cmd.kind == CMD_RUN && cmd.opaque) ? pending_r : cmd.count;
  assign cnt_ext = LW'(run_cnt);
  assign clamp   = (cnt_ext > left) ? left : cnt_ext;
  assign cmd_pop = !cmd_empty && !res_full;

  always_comb begin
    done_nxt         = done_r;
    ovr_nxt          = ovr_r;
    pending_nxt      = pending_r;
    res_push         = 1'b0;
    res.red          = cmd.red;
    res.green        = cmd.green;
    res.blue         = cmd.blue;
    res.alpha        = cmd.opaque ? ALPHA_OPAQUE : '0;
    res.repeat_count = clamp[LW_BITS-1:0];
    res.end_of_line  = 1'b0;
    res.overrun      = 1'b0;
    if (cmd_pop) begin
      unique case (cmd.kind)
        CMD_EOL: begin
          res_push         = 1'b1;
          res.red          = '0;
          res.green        = '0;
          res.blue         = '0;
          res.alpha        = '0;
          res.repeat_count = left[LW_BITS-1:0];
          res.end_of_line  = 1'b1;
          res.overrun      = ovr_r;
          done_nxt         = '0;
          ovr_nxt          = 1'b0;
        end
        CMD_HOLD: begin
          pending_nxt = clamp[5:0];
        end
        CMD_RUN: begin
          res_push    = 1'b1;
          done_nxt    = CW'(LW'(done_r) + clamp);
          pending_nxt = '0;
        end
        CMD_LIT: begin
          if (left == '0) begin
            ovr_nxt = 1'b1;
          end else begin
            res_push         = 1'b1;
            res.repeat_count = LW_BITS'(1);
            done_nxt         = done_r + 1'b1;
          end
        end
        default: begin
          done_nxt = done_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_width_r <= (LW'(LINE_WIDTH_RESET) > LW'(MAX_WIDTH)) ?
                     CW'(MAX_WIDTH) : CW'(LINE_WIDTH_RESET);
      done_r      <= '0;
      ovr_r       <= 1'b0;
      pending_r   <= '0;
    end else begin
      eff_width_r <= eff_width_nxt;
      done_r      <= done_nxt;
      ovr_r       <= ovr_nxt;
      pending_r   <= pending_nxt;
    end
  end

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.kind == CMD_EOL) |=> (done_r == '0 && !ovr_r))
    else $error("line state not cleared after end of line");

  a_ovr_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.overrun) |-> res.end_of_line)
    else $error("overrun flag on a run word");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!res_full && !cmd_empty))
    else $error("result word pushed without room or command");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
  import rrld_pkg::*;

  localparam int TOTAL_BYTES = 1700;
  localparam int CFG_SPACING = 150;
  localparam int HOLD_CYCLES = 400;

  class run_scoreboard;
    logic [LW_BITS-1:0] width;
    phase_t             phase;
    logic [6:0]         lit_left;
    logic [5:0]         run_len;
    logic [LW_BITS-1:0] done;
    logic [7:0]         blue_hold;
    logic [7:0]         green_hold;
    logic               ovr_flag;
    res_t               runs_due[$];
    int                 mismatches;
    int                 bytes_seen;
    int                 runs_seen;
    int                 lines_seen;
    int                 overrun_lines;

    function new();
      width = LINE_WIDTH_RESET;
      phase = PH_HEADER;
      lit_left = '0;
      run_len = '0;
      done = '0;
      blue_hold = '0;
      green_hold = '0;
      ovr_flag = 1'b0;
      mismatches = 0;
      bytes_seen = 0;
      runs_seen = 0;
      lines_seen = 0;
      overrun_lines = 0;
    endfunction

    function logic [LW_BITS-1:0] room();
      int eff;
      eff = (int'(width) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width);
      return (int'(done) < eff) ? LW_BITS'(eff - int'(done)) : '0;
    endfunction

    function void emit(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                       logic [LW_BITS-1:0] cnt, logic eol, logic ovr);
      res_t w;
      w.red = r;
      w.green = g;
      w.blue = b;
      w.alpha = a;
      w.repeat_count = cnt;
      w.end_of_line = eol;
      w.overrun = ovr;
      runs_due.push_back(w);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [LW_BITS-1:0] left;
      logic [LW_BITS-1:0] cnt;
      left = room();
      bytes_seen++;
      case (phase)
        PH_HEADER: begin
          if (b == HDR_EOL_HI || b == HDR_EOL_LO) begin
            emit(8'd0, 8'd0, 8'd0, 8'd0, left, 1'b1, ovr_flag);
            lines_seen++;
            if (ovr_flag) overrun_lines++;
            done = '0;
            ovr_flag = 1'b0;
          end else if (b[HDR_RUN_BIT]) begin
            cnt = LW_BITS'(b & RUN_MASK);
            if (cnt > left) cnt = left;
            if (b[HDR_ZERO_BIT]) begin
              done = done + cnt;
              emit(8'd0, 8'd0, 8'd0, 8'd0, cnt, 1'b0, 1'b0);
            end else begin
              run_len = cnt[5:0];
              phase = PH_RUN_B;
            end
          end else begin
            lit_left = b[6:0];
            phase = PH_LIT_B;
          end
        end
        PH_RUN_B: begin
          blue_hold = b;
          phase = PH_RUN_G;
        end
        PH_RUN_G: begin
          green_hold = b;
          phase = PH_RUN_R;
        end
        PH_RUN_R: begin
          cnt = LW_BITS'(run_len);
          if (cnt > left) cnt = left;
          done = done + cnt;
          run_len = '0;
          phase = PH_HEADER;
          emit(b, green_hold, blue_hold, ALPHA_OPAQUE, cnt, 1'b0, 1'b0);
        end
        PH_LIT_B: begin
          blue_hold = b;
          phase = PH_LIT_G;
        end
        PH_LIT_G: begin
          green_hold = b;
          phase = PH_LIT_R;
        end
        PH_LIT_R: begin
          lit_left = lit_left - 7'd1;
          phase = (lit_left == 7'd0) ? PH_HEADER : PH_LIT_B;
          if (left == '0) begin
            ovr_flag = 1'b1;
          end else begin
            done = done + 1'b1;
            emit(b, green_hold, blue_hold, ALPHA_OPAQUE, LW_BITS'(1), 1'b0, 1'b0);
          end
        end
        default: begin
          phase = PH_HEADER;
        end
      endcase
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_run(res_t got);
      res_t want;
      if (runs_due.size() == 0) begin
        $error("word with nothing expected: count %0d, end_of_line %0d",
               got.repeat_count, got.end_of_line);
        mismatches++;
        return;
      end
      want = runs_due.pop_front();
      runs_seen++;
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("alpha", want.alpha, got.alpha);
      compare("repeat_count", want.repeat_count, got.repeat_count);
      compare("end_of_line", want.end_of_line, got.end_of_line);
      compare("overrun", want.overrun, got.overrun);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [LW_BITS-1:0] cfg_line_width = LINE_WIDTH_RESET;
  logic               in_push = 1'b0;
  logic [7:0]         in_code_byte = 8'd0;
  logic               in_full;
  logic               out_pop = 1'b0;
  logic               out_empty;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [7:0]         out_alpha;
  logic [LW_BITS-1:0] out_repeat_count;
  logic               out_end_of_line;
  logic               out_overrun;

  run_scoreboard sb;
  int            n_sent = 0;
  int            n_cfg = 0;
  int            next_cfg = CFG_SPACING;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;

  rgb_rle_line_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_line_width   (cfg_line_width),
    .in_push          (in_push),
    .in_code_byte     (in_code_byte),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_repeat_count (out_repeat_count),
    .out_end_of_line  (out_end_of_line),
    .out_overrun      (out_overrun)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        sb.check_run(res_t'{out_red, out_green, out_blue, out_alpha, out_repeat_count,
                            out_end_of_line, out_overrun});
      end
      if (in_push && !in_full) sb.take_byte(in_code_byte);
      if (cfg_we) sb.width = cfg_line_width;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_push = 1'b1;
    in_code_byte = b;
    do @(posedge clk); while (in_full);
    n_sent++;
  endtask

  task automatic write_width(input logic [LW_BITS-1:0] w);
    @(negedge clk);
    in_push = 1'b0;
    while (sb.runs_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we = 1'b1;
    cfg_line_width = w;
    @(negedge clk);
    cfg_we = 1'b0;
    n_cfg++;
  endtask

  function automatic logic [LW_BITS-1:0] pick_width(int k);
    int sel;
    sel = (k < 8) ? k : int'($urandom_range(0, 7));
    case (sel)
      0: return '0;
      1: return LW_BITS'(1);
      2: return LINE_WIDTH_RESET;
      3: return '1;
      4: return LW_BITS'($urandom_range(DEF_MAX_WIDTH + 1, 8191));
      5: return LW_BITS'($urandom_range(0, 8191));
      default: return LW_BITS'($urandom_range(2, 48));
    endcase
  endfunction

  task automatic send_line();
    int nseg;
    int kind;
    int n;
    nseg = $urandom_range(1, 6);
    repeat (nseg) begin
      kind = $urandom_range(0, 24);
      if (kind == 0) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 8) begin
        send_byte(8'(8'hC0 | $urandom_range(0, 63)));
      end else if (kind < 15) begin
        send_byte(8'(8'h80 | $urandom_range(1, 63)));
        repeat (3) send_byte(8'($urandom_range(0, 255)));
      end else begin
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
        send_byte(8'(n));
        // drop the last color byte now and then to break the sequence
        repeat (3 * n - ((kind == 24) ? 1 : 0)) send_byte(8'($urandom_range(0, 255)));
      end
      if (n_sent >= next_cfg) begin
        write_width(pick_width(n_cfg));
        next_cfg += CFG_SPACING;
      end
    end
    send_byte($urandom_range(0, 1) ? HDR_EOL_HI : HDR_EOL_LO);
  endtask

  initial begin
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_pop = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [7:0] full_width_seq[] = '{8'hC0, 8'hFF, 8'hBF, 8'h00, 8'hFF, 8'hA5, 8'h80};
    logic [7:0] narrow_seq[] = '{8'h02, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                                 8'h84, 8'h10, 8'h20, 8'h30,
                                 8'h01, 8'hAA, 8'hBB, 8'hCC, 8'h00};
    logic [7:0] empty_seq[] = '{8'hC5, 8'h80};
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (full_width_seq[i]) send_byte(full_width_seq[i]);
    write_width(LW_BITS'(5));
    foreach (narrow_seq[i]) send_byte(narrow_seq[i]);
    write_width('0);
    foreach (empty_seq[i]) send_byte(empty_seq[i]);
    write_width('1);
    send_byte(HDR_EOL_LO);

    // stall the reader while bytes keep coming
    hold_req = 1'b1;
    while (n_sent < TOTAL_BYTES) begin
      if (n_sent > TOTAL_BYTES - 300) calm = 1'b1;
      send_line();
    end
    @(negedge clk);
    in_push = 1'b0;
    while (sb.runs_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("decoded %0d code bytes into %0d run words over %0d lines, %0d with overrun",
             sb.bytes_seen, sb.runs_seen, sb.lines_seen, sb.overrun_lines);
    $display("line width rewritten %0d times, reader held off for %0d cycles once",
             n_cfg, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- rgb_rle_line_decoder.f -----
rtl/rrld_pkg.sv
rtl/rrld_fifo.sv
rtl/rrld_front.sv
rtl/rrld_back.sv
rtl/rgb_rle_line_decoder.sv
bench/tb_top.sv
